>>> rtl/core/ttcb_pkg.sv
// Shared types and constants for the text terminal cell buffer.
// No dependencies; the cursor tracker and the top level refer to it by scoped names.
package ttcb_pkg;

   // One character cell as kept in the store
   typedef struct packed {
      logic [15:0] bg;
      logic [15:0] fg;
      logic [7:0]  ch;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   // Commands to the cursor tracker
   typedef struct packed {
      logic advance;
      logic scroll;
   } cur_cmd_type;

   // Status from the cursor tracker
   typedef struct packed {
      logic row_zero;
      logic full;
   } cur_stat_type;

   // Item opcodes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Register indexes on the configuration port
   localparam int  CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG = 1'b1;

   // Character codes and reset colors
   localparam logic [7:0]  CHAR_NUL   = 8'd0;
   localparam logic [7:0]  CHAR_LF    = 8'd10;
   localparam logic [7:0]  CHAR_SPACE = 8'd32;
   localparam logic [15:0] FG_RESET   = 16'h0000;
   localparam logic [15:0] BG_RESET   = 16'hFFFF;

endpackage

>>> rtl/core/ttcb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ttcb_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ttcb_cursor.sv
// Cursor tracker: keeps the linear cursor together with its row and column,
// so that scrolling needs no division. Depends on ttcb_pkg.
module ttcb_cursor #(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ttcb_pkg::cur_cmd_type                   cmd,
   output logic [$clog2(COLUMNS * ROWS + 1)-1:0]   cursor,
   output ttcb_pkg::cur_stat_type                  stat
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CUR_W = $clog2(CELLS + 1);
   localparam int ROW_W = $clog2(ROWS + 1);
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   logic [CUR_W-1:0] cur_ff, cur_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             row_zero;
   logic             full;

   assign row_zero = (row_ff == '0);
   assign full     = (cur_ff == CUR_W'(CELLS));

   // Advance by one cell, or return to the start of the row on scroll
   always_comb begin
      cur_in = cur_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.scroll) begin
         col_in = '0;
         if (row_zero) begin
            cur_in = '0;
         end else if (full) begin
            row_in = ROW_W'(ROWS - 1);
            cur_in = CUR_W'(CELLS - COLUMNS);
         end else begin
            cur_in = cur_ff - CUR_W'(col_ff);
         end
      end else if (cmd.advance) begin
         cur_in = cur_ff + 1'b1;
         if (col_ff == COL_W'(COLUMNS - 1)) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign cursor        = cur_ff;
   assign stat.row_zero = row_zero;
   assign stat.full     = full;

endmodule

>>> rtl/core/text_terminal_cell_buffer.sv
// Sequence: a put writes the cell at the cursor; a read fetches the indexed cell. A
// scroll comes first for a line feed or a full store: a row shift, then a blank row,
// or only a blank row on row 0; a printable character is then written. Only one item
// is in work at a time, set by the sweep through the single cell memory. Reset: a
// clearing pass writes every cell; no item is taken until it ends. Configuration
// writes are taken at all times.
module text_terminal_cell_buffer #(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,  // char_code[7:0], cell_index[13:8]
   input  logic                           req_tuser,  // opcode[0]
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,  // cell_char[7:0], cell_fg[23:8],
                                                      // cell_bg[39:24], cursor[46:40]
   // Configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ttcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CUR_W  = $clog2(CELLS + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_COPY  = 3'd4;
   localparam logic [2:0] ST_FILL  = 3'd5;
   localparam logic [2:0] ST_WRITE = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CUR_W-1:0]  src_ff, src_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              blank_ff, blank_in;
   logic              wr_after_ff, wr_after_in;

   logic              op_ff;
   logic [7:0]        ch_ff;
   logic [5:0]        idx_ff;
   ttcb_pkg::cell_type res_ff, res_in;

   logic [15:0]       fg_ff, bg_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_char_ff;
   logic [15:0]       rsp_fg_ff, rsp_bg_ff;
   logic [6:0]        rsp_cursor_ff;

   logic              req_accept;
   logic              rsp_load;
   logic              issue;
   logic [CUR_W-1:0]  copy_end;

   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   ttcb_pkg::cell_type ram_wr_data, ram_rd_data, ram_rd_cell;

   ttcb_pkg::cur_cmd_type  cur_cmd;
   ttcb_pkg::cur_stat_type cur_stat;
   logic [CUR_W-1:0]       cursor;

   ttcb_ram #(
      .WIDTH(ttcb_pkg::CELL_W),
      .DEPTH(CELLS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_cell)
   );

   assign ram_rd_data = ram_rd_cell;

   ttcb_cursor #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_cursor (
      .clock (clock),
      .reset (reset),
      .cmd   (cur_cmd),
      .cursor(cursor),
      .stat  (cur_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // Copy engine: read source cell, write it in the following cycle
   assign copy_end = blank_ff ? CUR_W'(COLUMNS) : CUR_W'(CELLS);
   assign issue    = (state_ff == ST_COPY) && (src_ff < copy_end);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      src_in      = src_ff;
      pend_in     = 1'b0;
      wr_addr_in  = wr_addr_ff;
      blank_in    = blank_ff;
      wr_after_in = wr_after_ff;
      res_in      = res_ff;
      cur_cmd     = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(cursor);
      ram_wr_data = '{bg: bg_ff, fg: fg_ff, ch: ch_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(src_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(src_ff);
            ram_wr_data = '{bg: ttcb_pkg::BG_RESET, fg: ttcb_pkg::FG_RESET,
                            ch: ttcb_pkg::CHAR_SPACE};
            if (src_ff == CUR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in = '0;
            if (op_ff == ttcb_pkg::OP_READ) begin
               if (32'(idx_ff) < CELLS) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(idx_ff);
                  state_in    = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (ch_ff == ttcb_pkg::CHAR_LF || cur_stat.full) begin
               // Scroll first; a printable character is written afterwards
               wr_after_in = (ch_ff != ttcb_pkg::CHAR_LF);
               blank_in    = cur_stat.row_zero;
               src_in      = cur_stat.row_zero ? '0 : CUR_W'(COLUMNS);
               state_in    = ST_COPY;
            end else begin
               ram_wr_en       = 1'b1;
               cur_cmd.advance = 1'b1;
               state_in        = ST_DONE;
            end
         end
         ST_READ: begin
            res_in   = ram_rd_data;
            state_in = ST_DONE;
         end
         ST_COPY: begin
            if (issue) begin
               ram_rd_en  = 1'b1;
               src_in     = src_ff + 1'b1;
               pend_in    = 1'b1;
               wr_addr_in = blank_ff ? ADDR_W'(src_ff) : ADDR_W'(src_ff - CUR_W'(COLUMNS));
            end
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_addr_ff;
               ram_wr_data = ram_rd_data;
               if (blank_ff) begin
                  ram_wr_data.ch = ttcb_pkg::CHAR_SPACE;
               end
            end
            if (!issue && !pend_ff) begin
               if (blank_ff) begin
                  cur_cmd.scroll = 1'b1;
                  state_in       = wr_after_ff ? ST_WRITE : ST_DONE;
               end else begin
                  src_in   = CUR_W'(CELLS - COLUMNS);
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(src_ff);
            ram_wr_data = '{bg: bg_ff, fg: fg_ff, ch: ttcb_pkg::CHAR_SPACE};
            if (src_ff == CUR_W'(CELLS - 1)) begin
               cur_cmd.scroll = 1'b1;
               state_in       = wr_after_ff ? ST_WRITE : ST_DONE;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            ram_wr_en       = 1'b1;
            cur_cmd.advance = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         src_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload registers of the item in work
   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      blank_ff    <= blank_in;
      wr_after_ff <= wr_after_in;
      res_ff      <= res_in;
      if (req_accept) begin
         op_ff  <= req_tuser;
         idx_ff <= req_tdata[13:8];
         // Store NUL as a space
         ch_ff  <= (req_tdata[7:0] == ttcb_pkg::CHAR_NUL) ? ttcb_pkg::CHAR_SPACE
                                                          : req_tdata[7:0];
      end
   end

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= ttcb_pkg::FG_RESET;
         bg_ff <= ttcb_pkg::BG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ttcb_pkg::CSR_FG: fg_ff <= csr_data;
            ttcb_pkg::CSR_BG: bg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Output register: hold the item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_char_ff   <= res_ff.ch;
         rsp_fg_ff     <= res_ff.fg;
         rsp_bg_ff     <= res_ff.bg;
         rsp_cursor_ff <= 7'(cursor);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cursor_ff, rsp_bg_ff, rsp_fg_ff, rsp_char_ff};

   // Cursor never passes the end of the store
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor <= CUR_W'(CELLS))
      else $error("cursor beyond cell count");

   // A scroll always leaves room for the next write
   a_scroll_room: assert property (@(posedge clock) disable iff (reset)
      cur_cmd.scroll |=> !cur_stat.full)
      else $error("cursor still at end after scroll");

   // The store is never written while waiting for an item
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_wr_en)
      else $error("store written while idle");

   // A put item returns zero cell fields
   a_put_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && op_ff == ttcb_pkg::OP_PUT) |=>
         (rsp_char_ff == '0 && rsp_fg_ff == '0 && rsp_bg_ff == '0))
      else $error("put result carries cell data");

endmodule
